[hdl/eafd_pkg.sv]
// Shared types and constants for the escaped API frame deframer.
package eafd_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned OFFS_W = 9;

    localparam logic [BYTE_W-1:0] ESC_BYTE       = 8'h7D;
    localparam logic [BYTE_W-1:0] START_BYTE     = 8'h7E;
    localparam logic [BYTE_W-1:0] ESC_XOR        = 8'h20;
    localparam logic [OFFS_W-1:0] LEN_EXTRA      = 9'd4;
    localparam logic [BYTE_W-1:0] RX_PACKET_KIND = 8'h90;

    localparam logic [OFFS_W-1:0] OFFS_LEN_LO = 9'd2;
    localparam logic [OFFS_W-1:0] OFFS_KIND   = 9'd3;

    // One raw link byte held in the input register.
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] raw_byte;
    } t_in_beat;

    // One deframed result beat.
    typedef struct packed {
        logic [BYTE_W-1:0] frame_byte;
        logic [OFFS_W-1:0] byte_offset;
        logic [BYTE_W-1:0] frame_kind;
        logic              last_of_frame;
        logic              receive_packet;
    } t_result;

endpackage

[hdl/eafd_in_reg.sv]
// Input register stage: holds one raw byte until the deframing core takes it.
module eafd_in_reg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [eafd_pkg::BYTE_W-1:0]     i_raw_byte,
    input  logic                            i_take,
    output eafd_pkg::t_in_beat              o_beat
);

    logic                         r_valid;
    logic [eafd_pkg::BYTE_W-1:0]  r_byte;

    // A new beat can enter whenever the stage is empty or drains this cycle.
    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_raw_byte;
        end
    end

    assign o_beat = {r_valid, r_byte};

endmodule

[hdl/eafd_core.sv]
// Deframing core: unescape, frame tracking and the registered result beat.
module eafd_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  eafd_pkg::t_in_beat  i_beat,
    output logic                o_take,
    output logic                o_valid,
    input  logic                i_ready,
    output eafd_pkg::t_result   o_result
);

    logic                         r_esc_pending;
    logic [eafd_pkg::OFFS_W-1:0]  r_bytes_taken;
    logic [eafd_pkg::OFFS_W-1:0]  r_frame_total;
    logic [eafd_pkg::BYTE_W-1:0]  r_captured_kind;
    logic                         r_out_valid;
    eafd_pkg::t_result            r_result;

    logic                         n_esc_pending;
    logic [eafd_pkg::OFFS_W-1:0]  n_bytes_taken;
    logic [eafd_pkg::OFFS_W-1:0]  n_frame_total;
    logic [eafd_pkg::BYTE_W-1:0]  n_captured_kind;

    logic                         is_esc;
    logic [eafd_pkg::BYTE_W-1:0]  unesc_byte;
    logic [eafd_pkg::OFFS_W-1:0]  offs;
    logic [eafd_pkg::OFFS_W:0]    offs_plus1;
    logic                         emit;
    logic                         last;
    logic [eafd_pkg::BYTE_W-1:0]  kind_now;
    eafd_pkg::t_result            result_next;

    // The result register is free when empty or being read out this cycle.
    assign o_take = i_beat.valid && (!r_out_valid || i_ready);

    assign is_esc     = (i_beat.raw_byte == eafd_pkg::ESC_BYTE);
    assign unesc_byte = r_esc_pending ? (i_beat.raw_byte ^ eafd_pkg::ESC_XOR)
                                      : i_beat.raw_byte;
    assign offs       = r_bytes_taken;
    assign offs_plus1 = {1'b0, offs} + {{eafd_pkg::OFFS_W{1'b0}}, 1'b1};

    always_comb begin
        n_esc_pending   = r_esc_pending;
        n_bytes_taken   = r_bytes_taken;
        n_frame_total   = r_frame_total;
        n_captured_kind = r_captured_kind;
        emit            = 1'b0;
        last            = 1'b0;
        kind_now        = r_captured_kind;

        if (is_esc) begin
            n_esc_pending = 1'b1;
        end else begin
            n_esc_pending = 1'b0;
            if (offs == '0) begin
                // Hunting: only a start byte opens a frame.
                if (unesc_byte == eafd_pkg::START_BYTE) begin
                    emit            = 1'b1;
                    n_frame_total   = '0;
                    n_captured_kind = '0;
                    kind_now        = '0;
                end
            end else begin
                emit = 1'b1;
                if (offs == eafd_pkg::OFFS_LEN_LO) begin
                    n_frame_total = {1'b0, unesc_byte} + eafd_pkg::LEN_EXTRA;
                end else if (offs >= eafd_pkg::OFFS_KIND) begin
                    if (offs == eafd_pkg::OFFS_KIND) begin
                        n_captured_kind = unesc_byte;
                        kind_now        = unesc_byte;
                    end
                    last = (offs_plus1 >= {1'b0, r_frame_total});
                end
            end
            if (emit) begin
                n_bytes_taken = last ? '0 : offs_plus1[eafd_pkg::OFFS_W-1:0];
            end
        end
    end

    always_comb begin
        result_next.frame_byte     = unesc_byte;
        result_next.byte_offset    = offs;
        result_next.frame_kind     = kind_now;
        result_next.last_of_frame  = last;
        result_next.receive_packet = (kind_now == eafd_pkg::RX_PACKET_KIND);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc_pending   <= 1'b0;
            r_bytes_taken   <= '0;
            r_frame_total   <= '0;
            r_captured_kind <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (o_take) begin
                r_esc_pending   <= n_esc_pending;
                r_bytes_taken   <= n_bytes_taken;
                r_frame_total   <= n_frame_total;
                r_captured_kind <= n_captured_kind;
            end
            if (o_take) begin
                r_out_valid <= emit;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && emit) begin
            r_result <= result_next;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

endmodule

[hdl/escaped_api_frame_deframer.sv]
// Top level of the escaped API frame deframer.
//
//   Channel   Direction  Handshake           Payload
//   input     in         i_valid / o_ready   i_raw_byte
//   result    out        o_valid / i_ready   o_frame_byte, o_byte_offset, o_frame_kind,
//                                            o_last_of_frame, o_receive_packet
//
// One raw byte is accepted per cycle while the result register is not stalled; a byte
// that yields a result shows it after passing the input register and then the result register.
// Escape bytes and bytes seen while hunting for a start byte yield no result.
// Reset is synchronous, active low, and returns the block to hunting.
// A stalled result register holds the input register, which then drops o_ready.
module escaped_api_frame_deframer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [eafd_pkg::BYTE_W-1:0]  i_raw_byte,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [eafd_pkg::BYTE_W-1:0]  o_frame_byte,
    output logic [eafd_pkg::OFFS_W-1:0]  o_byte_offset,
    output logic [eafd_pkg::BYTE_W-1:0]  o_frame_kind,
    output logic                         o_last_of_frame,
    output logic                         o_receive_packet
);

    eafd_pkg::t_in_beat  in_beat;
    eafd_pkg::t_result   result;
    logic                core_take;

    eafd_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_raw_byte (i_raw_byte),
        .i_take     (core_take),
        .o_beat     (in_beat)
    );

    eafd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_beat   (in_beat),
        .o_take   (core_take),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (result)
    );

    assign o_frame_byte     = result.frame_byte;
    assign o_byte_offset    = result.byte_offset;
    assign o_frame_kind     = result.frame_kind;
    assign o_last_of_frame  = result.last_of_frame;
    assign o_receive_packet = result.receive_packet;

endmodule

[dv/deframer_checker.sv]
// Checker for the escaped API frame deframer: predicts every result beat and compares.
`timescale 1ns / 1ps

module deframer_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [eafd_pkg::BYTE_W-1:0]   i_raw_byte,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [eafd_pkg::BYTE_W-1:0]   i_frame_byte,
    input  logic [eafd_pkg::OFFS_W-1:0]   i_byte_offset,
    input  logic [eafd_pkg::BYTE_W-1:0]   i_frame_kind,
    input  logic                          i_last_of_frame,
    input  logic                          i_receive_packet,
    output int                            o_fail_count,
    output int                            o_beats_owed
);

    logic                         unesc_pending;
    logic [eafd_pkg::OFFS_W-1:0]  frame_pos;
    logic [eafd_pkg::OFFS_W-1:0]  frame_len;
    logic [eafd_pkg::BYTE_W-1:0]  kind_seen;
    eafd_pkg::t_result            owed_beats[$];

    initial begin
        o_fail_count = 0;
        o_beats_owed = 0;
    end

    // Advances the deframing state by one raw byte and tells whether a beat comes out.
    task automatic deframe_byte(input logic [eafd_pkg::BYTE_W-1:0] raw, output bit emit,
                                output eafd_pkg::t_result beat);
        logic [eafd_pkg::BYTE_W-1:0] b;
        logic [eafd_pkg::OFFS_W-1:0] pos;
        logic                        last;
        b    = raw;
        emit = 1'b0;
        beat = '0;
        last = 1'b0;
        if (b == eafd_pkg::ESC_BYTE) begin
            unesc_pending = 1'b1;
            return;
        end
        if (unesc_pending) begin
            b             = b ^ eafd_pkg::ESC_XOR;
            unesc_pending = 1'b0;
        end
        pos = frame_pos;
        if (pos == '0) begin
            if (b != eafd_pkg::START_BYTE) return;
            frame_len = '0;
            kind_seen = '0;
        end else if (pos == eafd_pkg::OFFS_LEN_LO) begin
            frame_len = {1'b0, b} + eafd_pkg::LEN_EXTRA;
        end else if (pos >= eafd_pkg::OFFS_KIND) begin
            if (pos == eafd_pkg::OFFS_KIND) kind_seen = b;
            // The end test only applies once the length byte has been seen.
            if (pos + 9'd1 >= frame_len) last = 1'b1;
        end
        beat.frame_byte     = b;
        beat.byte_offset    = pos;
        beat.frame_kind     = kind_seen;
        beat.last_of_frame  = last;
        beat.receive_packet = (kind_seen == eafd_pkg::RX_PACKET_KIND);
        frame_pos = last ? '0 : pos + 9'd1;
        emit = 1'b1;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        eafd_pkg::t_result want;
        eafd_pkg::t_result predicted;
        bit                emit;
        if (!i_rst_n) begin
            unesc_pending = 1'b0;
            frame_pos     = '0;
            frame_len     = '0;
            kind_seen     = '0;
            owed_beats.delete();
        end else begin
            // Results go first: no byte accepted on this edge can have its result out yet.
            if (i_out_valid && i_out_ready) begin
                if (owed_beats.size() == 0) begin
                    $display("%0t ns: unexpected result beat, expected none, %s 0x%0h offset %0d",
                             $time, "actual byte", i_frame_byte, i_byte_offset);
                    o_fail_count++;
                end else begin
                    want = owed_beats.pop_front();
                    check_field("frame_byte", 32'(want.frame_byte), 32'(i_frame_byte));
                    check_field("byte_offset", 32'(want.byte_offset), 32'(i_byte_offset));
                    check_field("frame_kind", 32'(want.frame_kind), 32'(i_frame_kind));
                    check_field("last_of_frame", 32'(want.last_of_frame),
                                32'(i_last_of_frame));
                    check_field("receive_packet", 32'(want.receive_packet),
                                32'(i_receive_packet));
                end
            end
            if (i_in_valid && i_in_ready) begin
                deframe_byte(i_raw_byte, emit, predicted);
                if (emit) owed_beats.push_back(predicted);
            end
        end
        o_beats_owed = owed_beats.size();
    end

endmodule

[dv/testbench.sv]
// Top of the deframer testbench: clock, reset, link byte stimulus and the verdict.
`timescale 1ns / 1ps

module testbench;

    localparam int RAW_BYTES   = 1700;
    localparam int IDLE_PCT    = 20;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_valid = 1'b0;
    logic [eafd_pkg::BYTE_W-1:0]  i_raw_byte = '0;
    logic                         i_ready = 1'b0;
    logic                         o_ready;
    logic                         o_valid;
    logic [eafd_pkg::BYTE_W-1:0]  o_frame_byte;
    logic [eafd_pkg::OFFS_W-1:0]  o_byte_offset;
    logic [eafd_pkg::BYTE_W-1:0]  o_frame_kind;
    logic                         o_last_of_frame;
    logic                         o_receive_packet;
    int                           fail_count;
    int                           beats_owed;

    bit                calm_tx = 1'b0;
    bit                calm_rx = 1'b0;
    int                bytes_sent = 0;

    escaped_api_frame_deframer dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_raw_byte       (i_raw_byte),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_frame_byte     (o_frame_byte),
        .o_byte_offset    (o_byte_offset),
        .o_frame_kind     (o_frame_kind),
        .o_last_of_frame  (o_last_of_frame),
        .o_receive_packet (o_receive_packet)
    );

    deframer_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_ready       (o_ready),
        .i_raw_byte       (i_raw_byte),
        .i_out_valid      (o_valid),
        .i_out_ready      (i_ready),
        .i_frame_byte     (o_frame_byte),
        .i_byte_offset    (o_byte_offset),
        .i_frame_kind     (o_frame_kind),
        .i_last_of_frame  (o_last_of_frame),
        .i_receive_packet (o_receive_packet),
        .o_fail_count     (fail_count),
        .o_beats_owed     (beats_owed)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_ready <= calm_rx || ($urandom_range(99) >= IDLE_PCT);
    end

    // Presents one link byte, optionally after a short gap, and holds it until accepted.
    task automatic push_link_byte(input logic [eafd_pkg::BYTE_W-1:0] b);
        if (!calm_tx && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_raw_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        bytes_sent++;
    endtask

    // Sends a frame byte, escaped when it has to be and now and then when it need not.
    // 0x5D is never escaped by choice, since that would put two escape bytes in a row.
    task automatic push_frame_byte(input logic [eafd_pkg::BYTE_W-1:0] b);
        bit esc;
        esc = (b == eafd_pkg::ESC_BYTE) ||
              (b == eafd_pkg::START_BYTE && $urandom_range(1) == 1) ||
              ((b ^ eafd_pkg::ESC_XOR) != eafd_pkg::ESC_BYTE && $urandom_range(99) < 8);
        if (esc) begin
            push_link_byte(eafd_pkg::ESC_BYTE);
            push_link_byte(b ^ eafd_pkg::ESC_XOR);
        end else begin
            push_link_byte(b);
        end
    endtask

    // Sends the head of a frame and then body_len bytes after the length byte.
    task automatic push_frame(input logic [eafd_pkg::BYTE_W-1:0] len_lo, input int body_len);
        push_frame_byte(eafd_pkg::START_BYTE);
        push_frame_byte(8'($urandom_range(255)));
        push_frame_byte(len_lo);
        for (int k = 0; k < body_len; k++) begin
            if (k == 0 && $urandom_range(1) == 1) push_frame_byte(eafd_pkg::RX_PACKET_KIND);
            else push_frame_byte(8'($urandom_range(255)));
        end
    endtask

    task automatic drain_results();
        wait (beats_owed == 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic random_traffic(input int stop_at);
        int pick;
        int len;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
                if ($urandom_range(99) < 2) len = 255;
                else if ($urandom_range(99) < 5) len = $urandom_range(13, 254);
                else len = $urandom_range(0, 12);
                push_frame(8'(len), len + 1);
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 5)) push_link_byte(8'($urandom_range(255)));
            end else if (pick < 95) begin
                // A frame cut short: whatever follows is taken as its remaining bytes.
                len = $urandom_range(0, 20);
                push_frame(8'(len), int'($urandom_range(0, len)));
            end else begin
                push_link_byte(eafd_pkg::ESC_BYTE);
                push_link_byte(eafd_pkg::ESC_BYTE);
                push_link_byte(8'($urandom_range(255)));
            end
        end
    endtask

    initial begin : stimulus
        logic [eafd_pkg::BYTE_W-1:0] directed_seq [0:20] = '{
            8'h00, 8'hFF,
            8'h7E, 8'h00, 8'h00, 8'h90,
            8'h7D, 8'h5E, 8'h7D, 8'h20, 8'h01, 8'h7D, 8'h7D, 8'h5E, 8'h7E,
            8'h7E, 8'hFF, 8'h02, 8'hFF, 8'h00, 8'hFF
        };
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Discarded bytes while hunting, a zero length receive packet, an escaped start
        // with a double escape and a start byte as data, then a frame of extreme values.
        foreach (directed_seq[k]) push_link_byte(directed_seq[k]);
        i_valid <= 1'b0;
        drain_results();

        random_traffic(600);
        i_valid <= 1'b0;
        drain_results();

        calm_tx = 1'b1;
        calm_rx = 1'b1;
        random_traffic(1000);
        calm_tx = 1'b0;
        calm_rx = 1'b0;

        random_traffic(RAW_BYTES);
        i_valid <= 1'b0;
        wait (beats_owed == 0);
        repeat (10) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin : run_limit
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
